[sv/assert_macros.svh]
// Assertion macros shared by the RTL. Each one expands to a single labeled
// concurrent assertion sampled on aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define CLI_ASSERT(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("invariant violated");

// When trig holds, expect must hold at the next clock edge.
`define CLI_ASSERT_NEXT(name, trig, expect_c) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (expect_c)) else $error("sequence violated");

`endif

[sv/cli_pkg.sv]
`default_nettype none

package cli_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned PORT_CW = 7;
    localparam int unsigned GROUP_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_REWIND  = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_GET     = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_GRP  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/cli_cell.sv]
`default_nettype none

module cli_cell #(
    parameter int unsigned CW    = 7,
    parameter int unsigned IW    = 6,
    parameter int unsigned INDEX = 0
) (
    input  wire logic                       aclk,
    input  wire cli_pkg::cell_ctrl_t        ctrl,
    input  wire logic [CW-1:0]              cursor,
    input  wire logic [cli_pkg::WORD_W-1:0] left_data,
    input  wire logic [cli_pkg::WORD_W-1:0] right_data,
    input  wire logic [IW-1:0]              rd_idx,
    output logic      [cli_pkg::WORD_W-1:0] data,
    output logic      [cli_pkg::WORD_W-1:0] rd_word
);
    import cli_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(INDEX);
    localparam logic [IW-1:0] IDX_R = IW'(INDEX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins_en) begin
            if (IDX_C == cursor) begin
                data_next = ctrl.value;
            end else if (IDX_C > cursor) begin
                data_next = left_data;
            end
        end else if (ctrl.del_en && (IDX_C >= cursor)) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_word = (rd_idx == IDX_R) ? data_reg : '0;

endmodule

`default_nettype wire

[sv/cursor_list_insert_delete.sv]
`default_nettype none

// Cursor list: an ordered list of up to CAPACITY signed 32-bit words with
// one cursor, kept in a row of word cells that shift up on insert and down
// on delete, all in the same cycle. Each transfer on s_ carries a command
// (rewind, advance, insert, delete, get) and produces exactly one transfer
// on m_ with status, read word, end flag, entry count and cursor position.
// Timing: the block takes one command at a time and holds s_ready low from
// acceptance until its result transfer completes. Rewind, advance, insert,
// delete and unknown codes present their result in the cycle after
// acceptance; get first passes the states ST_GRP and ST_FIN while the two
// registered levels of the OR tree pick the addressed cell out of the row.
// Count and cursor outputs are 7 bits wide (low bits of the internal
// counters). Entries are not cleared at reset; only written ones are read.
module cursor_list_insert_delete #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // command channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [2:0]          s_command,
    input  wire logic signed [31:0]  s_value,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_ok,
    output logic signed [31:0]       m_read_value,
    output logic                     m_at_end,
    output logic [6:0]               m_entry_count,
    output logic [6:0]               m_cursor_position
);
    import cli_pkg::*;

`include "assert_macros.svh"

    // counter and cell index widths
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned NG  = (CAPACITY + GROUP_W - 1) / GROUP_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // control state
    state_t        state_reg,  state_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic          m_valid_reg, m_valid_next;

    // result and get bookkeeping
    logic              ok_reg,      ok_next;
    logic [WORD_W-1:0] rd_reg,      rd_next;
    logic [IW-1:0]     rd_idx_reg,  rd_idx_next;
    logic              get_ok_reg,  get_ok_next;
    logic              rd_zero_reg, rd_zero_next;

    cell_ctrl_t        ctrl;
    logic              accept;
    logic              cur_lt_cnt;
    logic [CW-1:0]     cur_m1;

    // cell row and read tree
    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [WORD_W-1:0] cell_rd   [CAPACITY];
    logic [WORD_W-1:0] grp_reg   [NG];
    logic [WORD_W-1:0] grp_or    [NG];
    logic [WORD_W-1:0] rd_final;

    // output widening so truncation works at any CW
    logic [CW+PORT_CW-1:0] count_wide;
    logic [CW+PORT_CW-1:0] cursor_wide;

    assign s_ready    = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept     = s_valid && s_ready;
    assign cur_lt_cnt = cursor_reg < count_reg;
    assign cur_m1     = cursor_reg - CW'(1);

    // command decode: update counters and launch the shift
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        m_valid_next = m_valid_reg;
        ok_next      = ok_reg;
        rd_next      = rd_reg;
        rd_idx_next  = rd_idx_reg;
        get_ok_next  = get_ok_reg;
        rd_zero_next = rd_zero_reg;
        ctrl.ins_en  = 1'b0;
        ctrl.del_en  = 1'b0;
        ctrl.value   = s_value;

        // drop the result once the transfer completes
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ok_next      = 1'b0;
                    rd_next      = '0;
                    m_valid_next = 1'b1;
                    unique case (s_command)
                        CMD_REWIND: begin
                            cursor_next = '0;
                            ok_next     = 1'b1;
                        end
                        CMD_ADVANCE: begin
                            if (cur_lt_cnt) begin
                                cursor_next = cursor_reg + CW'(1);
                                ok_next     = 1'b1;
                            end
                        end
                        CMD_INSERT: begin
                            if (count_reg < CAP_C) begin
                                count_next  = count_reg + CW'(1);
                                ok_next     = 1'b1;
                                ctrl.ins_en = 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (cur_lt_cnt) begin
                                count_next  = count_reg - CW'(1);
                                ok_next     = 1'b1;
                                ctrl.del_en = 1'b1;
                            end
                        end
                        CMD_GET: begin
                            // at the end, read the word just before the cursor
                            m_valid_next = 1'b0;
                            state_next   = ST_GRP;
                            get_ok_next  = cur_lt_cnt;
                            rd_zero_next = (count_reg == '0);
                            rd_idx_next  = cur_lt_cnt ? cursor_reg[IW-1:0]
                                                      : cur_m1[IW-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_GRP: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                state_next   = ST_IDLE;
                ok_next      = get_ok_reg;
                rd_next      = rd_zero_reg ? '0 : rd_final;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        ok_reg      <= ok_next;
        rd_reg      <= rd_next;
        rd_idx_reg  <= rd_idx_next;
        get_ok_reg  <= get_ok_next;
        rd_zero_reg <= rd_zero_next;
    end

    // row of word cells; on insert, cells past the cursor take their left
    // neighbor, on delete cells at or past it take their right neighbor
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_W-1:0] left_d;
        logic [WORD_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        cli_cell #(
            .CW    (CW),
            .IW    (IW),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cursor     (cursor_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .rd_idx     (rd_idx_reg),
            .data       (cell_data[i]),
            .rd_word    (cell_rd[i])
        );
    end

    // first read level: OR groups of eight masked cell words, registered
    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int unsigned LO = g * GROUP_W;
        localparam int unsigned HI = (LO + GROUP_W < CAPACITY) ? LO + GROUP_W : CAPACITY;

        always_comb begin
            grp_or[g] = '0;
            for (int unsigned k = LO; k < HI; k++) begin
                grp_or[g] = grp_or[g] | cell_rd[k];
            end
        end

        always_ff @(posedge aclk) begin
            grp_reg[g] <= grp_or[g];
        end
    end

    // second read level: OR the group words into the output register
    always_comb begin
        rd_final = '0;
        for (int unsigned g = 0; g < NG; g++) begin
            rd_final = rd_final | grp_reg[g];
        end
    end

    assign count_wide  = {{PORT_CW{1'b0}}, count_reg};
    assign cursor_wide = {{PORT_CW{1'b0}}, cursor_reg};

    // counters hold steady while a result waits, so drive them directly
    assign m_valid           = m_valid_reg;
    assign m_ok              = ok_reg;
    assign m_read_value      = signed'(rd_reg);
    assign m_at_end          = (cursor_reg == count_reg);
    assign m_entry_count     = count_wide[PORT_CW-1:0];
    assign m_cursor_position = cursor_wide[PORT_CW-1:0];

    // checks
    `CLI_ASSERT(a_cursor_in_list, cursor_reg <= count_reg)
    `CLI_ASSERT(a_count_in_cap, count_reg <= CAP_C)
    `CLI_ASSERT(a_no_intake_while_held, !(s_ready && m_valid_reg))
    `CLI_ASSERT_NEXT(a_read_tree_steps, state_reg == ST_GRP, state_reg == ST_FIN)

endmodule

`default_nettype wire

[verif/cursor_list_insert_delete_checker.sv]
module cursor_list_insert_delete_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic signed [31:0] s_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_ok,
    input  logic signed [31:0] m_read_value,
    input  logic               m_at_end,
    input  logic [6:0]         m_entry_count,
    input  logic [6:0]         m_cursor_position,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cli_pkg::*;

    typedef struct {
        logic               ok;
        logic signed [31:0] read_value;
        logic               at_end;
        logic [6:0]         entry_count;
        logic [6:0]         cursor_position;
    } list_result_t;

    // Shadow copy of the list
    logic signed [31:0] cells [CAPACITY];
    int unsigned        list_len = 0;
    int unsigned        cur_pos = 0;

    list_result_t expected_results [$];
    int           mismatches = 0;
    int           waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    function automatic list_result_t apply_list_command(
        input logic [2:0]         cmd,
        input logic signed [31:0] word
    );
        list_result_t r;
        r.ok         = 1'b0;
        r.read_value = '0;
        case (cmd)
            CMD_REWIND: begin
                cur_pos = 0;
                r.ok    = 1'b1;
            end
            CMD_ADVANCE: begin
                if (cur_pos < list_len) begin
                    cur_pos++;
                    r.ok = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (list_len < CAPACITY) begin
                    for (int i = list_len; i > cur_pos; i--)
                        cells[i] = cells[i-1];
                    cells[cur_pos] = word;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (cur_pos < list_len) begin
                    for (int i = cur_pos + 1; i < list_len; i++)
                        cells[i-1] = cells[i];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            CMD_GET: begin
                if (cur_pos < list_len) begin
                    r.read_value = cells[cur_pos];
                    r.ok         = 1'b1;
                end else if (cur_pos > 0) begin
                    // at the end: return the word just behind the cursor
                    r.read_value = cells[cur_pos-1];
                end
            end
            default: ;
        endcase
        r.at_end          = (cur_pos == list_len);
        r.entry_count     = 7'(list_len);
        r.cursor_position = 7'(cur_pos);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        list_result_t want;
        if (!aresetn) begin
            expected_results.delete();
            list_len = 0;
            cur_pos  = 0;
            waiting <= 0;
        end else begin
            // Retire results before queuing the command taken at this edge
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, m_ok);
                        mismatches++;
                    end
                    if (m_read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, m_read_value);
                        mismatches++;
                    end
                    if (m_at_end !== want.at_end) begin
                        $error("at_end: expected %0d, got %0d", want.at_end, m_at_end);
                        mismatches++;
                    end
                    if (m_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_entry_count);
                        mismatches++;
                    end
                    if (m_cursor_position !== want.cursor_position) begin
                        $error("cursor_position: expected %0d, got %0d",
                               want.cursor_position, m_cursor_position);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_list_command(s_command, s_value));
            waiting <= expected_results.size();
        end
    end

endmodule

[verif/cursor_list_insert_delete_tb.sv]
module cursor_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cli_pkg::*;

    localparam int unsigned LIST_CAPACITY = 64;

    // Command codes the block does not decode; they must leave the list alone
    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    // Command mixes for random bursts
    localparam int MIX_GROW     = 0;
    localparam int MIX_SHRINK   = 1;
    localparam int MIX_BALANCED = 2;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command = CMD_REWIND;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_ok;
    logic signed [31:0] m_read_value;
    logic               m_at_end;
    logic [6:0]         m_entry_count;
    logic [6:0]         m_cursor_position;

    int fail_count;
    int pending;

    // Idle odds in percent, changed per phase by the stimulus process
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    always #6 aclk = ~aclk;

    cursor_list_insert_delete #(
        .CAPACITY(LIST_CAPACITY)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_read_value      (m_read_value),
        .m_at_end          (m_at_end),
        .m_entry_count     (m_entry_count),
        .m_cursor_position (m_cursor_position)
    );

    cursor_list_insert_delete_checker #(
        .CAPACITY(LIST_CAPACITY)
    ) list_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_read_value      (m_read_value),
        .m_at_end          (m_at_end),
        .m_entry_count     (m_entry_count),
        .m_cursor_position (m_cursor_position),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    // Result side: stall at random with the current phase's odds.
    // A zero setting keeps m_ready high for whole stretches.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one command and hold it until the transfer completes.
    // Idle cycles are inserted first; valid is only dropped in a step where
    // it is not raised again, so back-to-back commands keep it high.
    task automatic drive_cmd(input logic [2:0] cmd, input logic signed [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= word;
        @(posedge aclk);
        // s_ready read here is the value seen by the edge just taken
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid and hold off until every outstanding result is back.
    // pending is updated by a nonblocking assignment, so step the clock before looking at it.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Full-range random words half the time, corner values the other half
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_cmd(input int mix);
        int r;
        int ins_w;
        int del_w;
        r     = $urandom_range(99);
        ins_w = (mix == MIX_GROW) ? 45 : (mix == MIX_SHRINK) ? 10 : 25;
        del_w = (mix == MIX_SHRINK) ? 45 : (mix == MIX_GROW) ? 10 : 25;
        if (r < 3) begin
            case ($urandom_range(2))
                0:       return CMD_RSVD_5;
                1:       return CMD_RSVD_6;
                default: return CMD_RSVD_7;
            endcase
        end
        if (r < 3 + ins_w)
            return CMD_INSERT;
        if (r < 3 + ins_w + del_w)
            return CMD_DELETE;
        case (r % 5)
            0:       return CMD_REWIND;
            1, 2:    return CMD_ADVANCE;
            default: return CMD_GET;
        endcase
    endfunction

    // Fill the store to capacity, walk the cursor to the very end, probe
    // the full and end corners, then delete everything from the front.
    task automatic fill_and_empty();
        drive_cmd(CMD_REWIND, rand_word());
        // more inserts than cells: the tail ones must be refused
        repeat ($urandom_range(66, 70)) drive_cmd(CMD_INSERT, rand_word());
        // one advance past the last entry must fail
        repeat (LIST_CAPACITY + 1) begin
            if ($urandom_range(3) == 0)
                drive_cmd(CMD_GET, rand_word());
            drive_cmd(CMD_ADVANCE, rand_word());
        end
        drive_cmd(CMD_GET, rand_word());
        drive_cmd(CMD_DELETE, rand_word());
        drive_cmd(CMD_INSERT, rand_word());
        drive_cmd(CMD_REWIND, rand_word());
        repeat (LIST_CAPACITY + 2) begin
            if ($urandom_range(3) == 0)
                drive_cmd(CMD_GET, rand_word());
            drive_cmd(CMD_DELETE, rand_word());
        end
    endtask

    // Random bursts with a bias toward growing, shrinking or neither,
    // now and then a full fill/empty sweep.
    task automatic run_random_segment(input bit with_fill, input int quota);
        int first;
        int mix;
        first = items_sent;
        if (with_fill)
            fill_and_empty();
        while (items_sent - first < quota) begin
            if ($urandom_range(59) == 0) begin
                fill_and_empty();
            end else begin
                mix = $urandom_range(2);
                repeat ($urandom_range(5, 30)) drive_cmd(pick_cmd(mix), rand_word());
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list corners, undecoded codes, extreme words,
        // get and delete at the end of a non-empty list.
        drive_cmd(CMD_GET, 32'h1234_5678);
        drive_cmd(CMD_ADVANCE, '0);
        drive_cmd(CMD_DELETE, '0);
        drive_cmd(CMD_RSVD_5, 32'hdead_beef);
        drive_cmd(CMD_RSVD_6, 32'hffff_ffff);
        drive_cmd(CMD_RSVD_7, 32'h8000_0000);
        drive_cmd(CMD_INSERT, 32'h7fff_ffff);
        drive_cmd(CMD_INSERT, 32'h8000_0000);
        drive_cmd(CMD_GET, '0);
        drive_cmd(CMD_ADVANCE, '0);
        drive_cmd(CMD_INSERT, 32'h0000_0000);
        drive_cmd(CMD_INSERT, 32'hffff_ffff);
        drive_cmd(CMD_GET, '0);
        repeat (3) drive_cmd(CMD_ADVANCE, '0);
        drive_cmd(CMD_ADVANCE, '0);
        drive_cmd(CMD_GET, '0);
        drive_cmd(CMD_DELETE, '0);
        drive_cmd(CMD_REWIND, 32'h5a5a_5a5a);
        drive_cmd(CMD_DELETE, '0);
        drive_cmd(CMD_GET, '0);
        drive_cmd(CMD_INSERT, 32'h5555_aaaa);
        wait_for_results();

        // Random part in phases: clean, sender gaps, receiver stalls, both.
        // Drain at every phase change so the sender sits out a full flush.
        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            run_random_segment(seg % 4 == 1, 205);
            wait_for_results();
        end

        // Keep m_ready up so any stray result shows in the tail window
        recv_stall_pct = 0;
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #6ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/cli_pkg.sv
sv/cli_cell.sv
sv/cursor_list_insert_delete.sv
verif/cursor_list_insert_delete_checker.sv
verif/cursor_list_insert_delete_tb.sv
